@@ design/r16ie_pkg.sv @@
// ----------------------------------------------------------------------------
// r16ie_pkg
// Shared types, field widths and instruction codes of the 16-bit execute core.
// ----------------------------------------------------------------------------
package r16ie_pkg;

	localparam int WORD_BITS      = 16;
	localparam int REG_COUNT      = 8;
	localparam int REG_IDX_W      = 3;
	localparam int FUNC_W         = 2;
	localparam int MEM_ADDR_W     = 11;
	localparam int FLAGS_W        = 4;
	localparam int SHAMT_W        = 4;
	localparam int DATA_DEPTH_DEF = 2048;

	// Load/store address sums span one sign-extended word plus an 8-bit offset.
	localparam int ADDR_SUM_W   = 17;
	localparam int DISP_HALF    = 128;
	localparam int DISP_SPAN    = 256;
	localparam int ADDR_MIN_MAG = 32768 + DISP_HALF;

	// Stream payload widths.
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 88;

	// Item kinds carried on the input tuser.
	localparam logic [FUNC_W-1:0] FUNC_EXEC      = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MEM_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MEM_READ  = 2'd2;

	// Major opcodes, instr[15:14].
	localparam logic [1:0] OP1_LD  = 2'd0;
	localparam logic [1:0] OP1_ST  = 2'd1;
	localparam logic [1:0] OP1_BR  = 2'd2;
	localparam logic [1:0] OP1_ALU = 2'd3;

	// Branch-group sub-opcodes, instr[13:11].
	localparam logic [2:0] OP2_LI = 3'd0;
	localparam logic [2:0] OP2_B  = 3'd4;
	localparam logic [2:0] IS_IF  = 3'd7;

	// Conditions, instr[10:8].
	localparam logic [2:0] COND_EQ = 3'd0;
	localparam logic [2:0] COND_LT = 3'd1;
	localparam logic [2:0] COND_LE = 3'd2;
	localparam logic [2:0] COND_NE = 3'd3;

	// ALU-group sub-opcodes, instr[7:4].
	localparam logic [3:0] OP3_ADD = 4'd0;
	localparam logic [3:0] OP3_SUB = 4'd1;
	localparam logic [3:0] OP3_AND = 4'd2;
	localparam logic [3:0] OP3_OR  = 4'd3;
	localparam logic [3:0] OP3_XOR = 4'd4;
	localparam logic [3:0] OP3_CMP = 4'd5;
	localparam logic [3:0] OP3_MOV = 4'd6;
	localparam logic [3:0] OP3_SLL = 4'd8;
	localparam logic [3:0] OP3_ROL = 4'd9;
	localparam logic [3:0] OP3_SRL = 4'd10;
	localparam logic [3:0] OP3_SRA = 4'd11;
	localparam logic [3:0] HLT     = 4'd15;

	// Flag bit positions.
	localparam int FLAG_Z = 3;
	localparam int FLAG_S = 2;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 0;

	// One result beat; the first member sits in the highest bits.
	typedef struct packed {
		logic [WORD_BITS-1:0]  read_data;
		logic [WORD_BITS-1:0]  mem_write_value;
		logic [MEM_ADDR_W-1:0] mem_write_addr;
		logic                  mem_write_en;
		logic [WORD_BITS-1:0]  reg_write_value;
		logic [REG_IDX_W-1:0]  reg_write_index;
		logic                  reg_write_en;
		logic [FLAGS_W-1:0]    flags;
		logic                  halted;
		logic [WORD_BITS-1:0]  next_pc;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	// Execute-stage outcome handed to the memory stage.
	typedef struct packed {
		result_t res;
		logic    load;
		logic    host_read;
	} exec_out_t;

endpackage

@@ design/r16ie_regfile.sv @@
// ----------------------------------------------------------------------------
// r16ie_regfile
// Eight-word register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module r16ie_regfile
	import r16ie_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [REG_IDX_W-1:0] rd_a_idx,
	input  logic [REG_IDX_W-1:0] rd_b_idx,
	output logic [WORD_BITS-1:0] rd_a_data,
	output logic [WORD_BITS-1:0] rd_b_data,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_idx,
	input  logic [WORD_BITS-1:0] wr_data
);

	logic [WORD_BITS-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [WORD_BITS-1:0] rd_a_q;
	logic [WORD_BITS-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// An entry that was never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// A write in the same cycle is forwarded into the read register.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_a_idx)) begin
				rd_a_q <= wr_data;
			end else if (vld_q[rd_a_idx]) begin
				rd_a_q <= mem[rd_a_idx];
			end else begin
				rd_a_q <= '0;
			end
			if (wr_en && (wr_idx == rd_b_idx)) begin
				rd_b_q <= wr_data;
			end else if (vld_q[rd_b_idx]) begin
				rd_b_q <= mem[rd_b_idx];
			end else begin
				rd_b_q <= '0;
			end
		end
	end

	assign rd_a_data = rd_a_q;
	assign rd_b_data = rd_b_q;

endmodule

@@ design/r16ie_dmem.sv @@
// ----------------------------------------------------------------------------
// r16ie_dmem
// Single-port data memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module r16ie_dmem
	import r16ie_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	localparam int AW        = $clog2(DATA_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 busy,
	input  logic                 acc_we,
	input  logic                 acc_re,
	input  logic [AW-1:0]        acc_addr,
	input  logic [WORD_BITS-1:0] acc_wdata,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [DATA_DEPTH];
	logic                 clr_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 w_en;
	logic [AW-1:0]        w_addr;
	logic [WORD_BITS-1:0] w_data;
	logic [WORD_BITS-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DATA_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_comb begin
		w_en   = clr_q | acc_we;
		w_addr = clr_q ? clr_addr_q : acc_addr;
		w_data = clr_q ? '0 : acc_wdata;
	end

	always_ff @(posedge clk) begin
		if (w_en) begin
			mem[w_addr] <= w_data;
		end
		if (acc_re) begin
			rd_q <= mem[acc_addr];
		end
	end

	assign busy    = clr_q;
	assign rd_data = rd_q;

endmodule

@@ design/r16ie_addr_mod.sv @@
// ----------------------------------------------------------------------------
// r16ie_addr_mod
// Reduces a signed address sum to a data memory index modulo the depth.
// ----------------------------------------------------------------------------
module r16ie_addr_mod
	import r16ie_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	localparam int AW        = $clog2(DATA_DEPTH)
) (
	input  logic signed [ADDR_SUM_W-1:0] sum,
	output logic        [AW-1:0]         idx
);

	localparam bit IS_POW2 = (DATA_DEPTH & (DATA_DEPTH - 1)) == 0;

	if (IS_POW2) begin : g_pow2
		// Two's complement low bits are already the modulo.
		assign idx = sum[AW-1:0];
	end else begin : g_tab
		// Bias by a multiple of the depth to make the sum non-negative, then
		// fold the upper chunk through a constant table of (hi * 512) mod depth.
		localparam int OFF     = DATA_DEPTH * ((ADDR_MIN_MAG + DATA_DEPTH - 1) / DATA_DEPTH);
		localparam int LO_W    = 9;
		localparam int BIAS_W  = 18;
		localparam int TAB_N   = 257;
		localparam int RED_W   = AW + 2;

		logic signed [BIAS_W:0] biased;
		logic [BIAS_W-1:0]      v;
		logic [LO_W-1:0]        hi;
		logic [LO_W-1:0]        lo;
		logic [AW-1:0]          tab [TAB_N];
		logic [RED_W-1:0]       sum0;
		logic [RED_W-1:0]       red1;
		logic [RED_W-1:0]       red2;

		for (genvar i = 0; i < TAB_N; i++) begin : g_ent
			assign tab[i] = AW'((i * (1 << LO_W)) % DATA_DEPTH);
		end

		always_comb begin
			biased = (BIAS_W + 1)'(sum) + (BIAS_W + 1)'(OFF);
			v      = biased[BIAS_W-1:0];
			hi     = v[BIAS_W-1:LO_W];
			lo     = v[LO_W-1:0];
			sum0   = RED_W'(tab[hi]) + RED_W'(lo);
			red1   = (sum0 >= RED_W'(DATA_DEPTH)) ? sum0 - RED_W'(DATA_DEPTH) : sum0;
			red2   = (red1 >= RED_W'(DATA_DEPTH)) ? red1 - RED_W'(DATA_DEPTH) : red1;
			idx    = red2[AW-1:0];
		end
	end

endmodule

@@ design/r16ie_exec.sv @@
// ----------------------------------------------------------------------------
// r16ie_exec
// Execute stage: decode, ALU, branch resolution and memory access request.
// ----------------------------------------------------------------------------
module r16ie_exec
	import r16ie_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	localparam int AW        = $clog2(DATA_DEPTH)
) (
	input  logic [FUNC_W-1:0]     func,
	input  logic [WORD_BITS-1:0]  instr,
	input  logic [MEM_ADDR_W-1:0] host_addr,
	input  logic [WORD_BITS-1:0]  host_data,
	input  logic [WORD_BITS-1:0]  ra_val,
	input  logic [WORD_BITS-1:0]  rb_val,
	input  logic [WORD_BITS-1:0]  pc,
	input  logic [FLAGS_W-1:0]    flags,
	input  logic                  halted,
	output exec_out_t             eo,
	output logic                  dm_we,
	output logic                  dm_re,
	output logic [AW-1:0]         dm_addr,
	output logic [WORD_BITS-1:0]  dm_wdata
);

	logic [1:0]                   op1;
	logic [REG_IDX_W-1:0]         fa;
	logic [REG_IDX_W-1:0]         fb;
	logic [3:0]                   op3;
	logic [SHAMT_W-1:0]           sh;
	logic [WORD_BITS-1:0]         d8_ext;
	logic [WORD_BITS-1:0]         npc;
	logic [WORD_BITS-1:0]         br_tgt;
	logic signed [ADDR_SUM_W-1:0] ldst_sum;
	logic signed [ADDR_SUM_W-1:0] host_sum;
	logic [AW-1:0]                ldst_idx;
	logic [AW-1:0]                host_idx;
	logic [AW+MEM_ADDR_W-1:0]     ldst_idx_ext;
	logic                         cond_z;
	logic                         cond_lt;
	logic                         take;
	logic [WORD_BITS-1:0]         alu_r;
	logic [2*WORD_BITS-1:0]       rot;
	logic                         alu_has;
	logic                         alu_wr;
	logic                         alu_v;
	logic [FLAGS_W-1:0]           alu_flags;

	assign op1      = instr[15:14];
	assign fa       = instr[13:11];
	assign fb       = instr[10:8];
	assign op3      = instr[7:4];
	assign sh       = instr[SHAMT_W-1:0];
	assign d8_ext   = WORD_BITS'($signed(instr[7:0]));
	assign npc      = pc + 1'b1;
	assign br_tgt   = npc + d8_ext;
	assign ldst_sum = ADDR_SUM_W'($signed(rb_val)) + ADDR_SUM_W'($signed(instr[7:0]));
	assign host_sum = ADDR_SUM_W'(host_addr);
	assign ldst_idx_ext = (AW + MEM_ADDR_W)'(ldst_idx);

	r16ie_addr_mod #(.DATA_DEPTH(DATA_DEPTH)) u_ldst_mod (
		.sum (ldst_sum),
		.idx (ldst_idx)
	);

	r16ie_addr_mod #(.DATA_DEPTH(DATA_DEPTH)) u_host_mod (
		.sum (host_sum),
		.idx (host_idx)
	);

	// ALU: x is the rd/rb operand, y the rs/ra operand.
	always_comb begin
		alu_r   = '0;
		alu_has = 1'b1;
		alu_wr  = 1'b1;
		alu_v   = 1'b0;
		rot     = {rb_val, rb_val} << sh;
		case (op3)
			OP3_ADD: begin
				alu_r = rb_val + ra_val;
				alu_v = (rb_val[15] == ra_val[15]) && (alu_r[15] != rb_val[15]);
			end
			OP3_SUB, OP3_CMP: begin
				alu_r  = rb_val - ra_val;
				alu_v  = (rb_val[15] != ra_val[15]) && (alu_r[15] != rb_val[15]);
				alu_wr = (op3 == OP3_SUB);
			end
			OP3_AND: alu_r = rb_val & ra_val;
			OP3_OR:  alu_r = rb_val | ra_val;
			OP3_XOR: alu_r = rb_val ^ ra_val;
			OP3_MOV: alu_r = ra_val;
			OP3_SLL: alu_r = rb_val << sh;
			OP3_ROL: alu_r = rot[2*WORD_BITS-1:WORD_BITS];
			OP3_SRL: alu_r = rb_val >> sh;
			OP3_SRA: alu_r = WORD_BITS'($signed(rb_val) >>> sh);
			default: begin
				alu_has = 1'b0;
				alu_wr  = 1'b0;
			end
		endcase
		alu_flags         = '0;
		alu_flags[FLAG_Z] = alu_has && (alu_r == '0);
		alu_flags[FLAG_S] = alu_has && alu_r[15];
		alu_flags[FLAG_C] = alu_v;
		alu_flags[FLAG_V] = alu_v;
	end

	always_comb begin
		cond_z  = flags[FLAG_Z];
		cond_lt = flags[FLAG_S] ^ flags[FLAG_V];
		case (fb)
			COND_EQ: take = cond_z;
			COND_LT: take = cond_lt;
			COND_LE: take = cond_z | cond_lt;
			COND_NE: take = !cond_z;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		eo           = '0;
		eo.res.next_pc = pc;
		eo.res.halted  = halted;
		eo.res.flags   = flags;
		dm_we        = 1'b0;
		dm_re        = 1'b0;
		dm_addr      = ldst_idx;
		dm_wdata     = ra_val;
		case (func)
			FUNC_MEM_WRITE: begin
				dm_we    = 1'b1;
				dm_addr  = host_idx;
				dm_wdata = host_data;
			end
			FUNC_MEM_READ: begin
				dm_re        = 1'b1;
				dm_addr      = host_idx;
				eo.host_read = 1'b1;
			end
			FUNC_EXEC: begin
				if (!halted) begin
					eo.res.next_pc = npc;
					case (op1)
						OP1_LD: begin
							dm_re                  = 1'b1;
							eo.load                = 1'b1;
							eo.res.reg_write_en    = 1'b1;
							eo.res.reg_write_index = fa;
						end
						OP1_ST: begin
							dm_we                  = 1'b1;
							eo.res.mem_write_en    = 1'b1;
							eo.res.mem_write_addr  = ldst_idx_ext[MEM_ADDR_W-1:0];
							eo.res.mem_write_value = ra_val;
						end
						OP1_BR: begin
							case (fa)
								OP2_LI: begin
									eo.res.reg_write_en    = 1'b1;
									eo.res.reg_write_index = fb;
									eo.res.reg_write_value = d8_ext;
								end
								OP2_B: eo.res.next_pc = br_tgt;
								IS_IF: begin
									if (take) begin
										eo.res.next_pc = br_tgt;
									end
								end
								default: ;
							endcase
						end
						default: begin
							eo.res.flags = alu_flags;
							if (op3 == HLT) begin
								eo.res.halted = 1'b1;
							end
							if (alu_wr) begin
								eo.res.reg_write_en    = 1'b1;
								eo.res.reg_write_index = fb;
								eo.res.reg_write_value = alu_r;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/risc16_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// risc16_instruction_execute
// Execute core of a small 16-bit processor with register file and data memory.
// ----------------------------------------------------------------------------
// Each input beat is one item: an instruction to execute (tuser 0), a host write
// of a data memory word (tuser 1) or a host read (tuser 2); kind 3 changes
// nothing. Every item yields one result beat showing the pc, halt state and
// flags after it, together with any register write or store it made and, for
// a host read, the word read. The caller fetches each instruction at the
// next_pc of the previous result. The core takes no new item while one is in
// the execute stage: the register file is read at the accepting edge and the
// data memory is accessed by the following execute stage, with load data
// written back one stage later. A result beat passes the execute and
// memory/write-back stages and waits in a two-beat output buffer, so a stalled
// output side blocks the next item only once the beats buffered and in flight
// would fill that buffer. After reset the data memory is swept to zero, one
// word a cycle, and no item is accepted until the sweep is done.
// A non-power-of-two DATA_DEPTH is supported; addresses wrap modulo the depth.
module risc16_instruction_execute
	import r16ie_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input: tdata = instr[15:0], mem_addr[26:16], mem_data[42:27], zero pad.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// Input: tuser = func[1:0].
	input  logic [FUNC_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Output: tdata = next_pc[15:0], halted[16], flags[20:17], reg_write_en[21],
	// reg_write_index[24:22], reg_write_value[40:25], mem_write_en[41],
	// mem_write_addr[52:42], mem_write_value[68:53], read_data[84:69], zero pad.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int AW = $clog2(DATA_DEPTH);

	// Input beat fields.
	logic [WORD_BITS-1:0]  in_instr;
	logic [MEM_ADDR_W-1:0] in_addr;
	logic [WORD_BITS-1:0]  in_data;
	logic                  in_accept;

	// Execute stage.
	logic                  valid_s1;
	logic [FUNC_W-1:0]     func_s1;
	logic [WORD_BITS-1:0]  instr_s1;
	logic [MEM_ADDR_W-1:0] haddr_s1;
	logic [WORD_BITS-1:0]  hdata_s1;

	// Architectural state held outside the memories.
	logic [WORD_BITS-1:0]  pc_q;
	logic [FLAGS_W-1:0]    flags_q;
	logic                  halted_q;

	// Memory / write-back stage.
	logic                  valid_s2;
	result_t               res_s2;
	logic                  load_s2;
	logic                  hread_s2;
	result_t               res_fin;

	// Register file and data memory connections.
	logic [WORD_BITS-1:0]  ra_val;
	logic [WORD_BITS-1:0]  rb_val;
	logic                  rf_we;
	exec_out_t             eo;
	logic                  dm_we;
	logic                  dm_re;
	logic [AW-1:0]         dm_addr;
	logic [WORD_BITS-1:0]  dm_wdata;
	logic [WORD_BITS-1:0]  dm_rdata;
	logic                  dm_busy;

	// Two-beat result buffer.
	result_t               buf_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  out_pop;

	assign in_instr = s_axis_tdata[15:0];
	assign in_addr  = s_axis_tdata[26:16];
	assign in_data  = s_axis_tdata[42:27];

	// One item in the execute stage at a time, and the buffer must have room
	// for every beat still in flight plus this one.
	assign s_axis_tready = !dm_busy && !valid_s1 &&
		((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !valid_s2));
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// The register file is read at the accepting edge; a register write at
	// that same edge is forwarded inside the register file.
	r16ie_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_accept),
		.rd_a_idx  (in_instr[13:11]),
		.rd_b_idx  (in_instr[10:8]),
		.rd_a_data (ra_val),
		.rd_b_data (rb_val),
		.wr_en     (rf_we),
		.wr_idx    (res_fin.reg_write_index),
		.wr_data   (res_fin.reg_write_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1  <= s_axis_tuser;
			instr_s1 <= in_instr;
			haddr_s1 <= in_addr;
			hdata_s1 <= in_data;
		end
	end

	r16ie_exec #(.DATA_DEPTH(DATA_DEPTH)) u_exec (
		.func      (func_s1),
		.instr     (instr_s1),
		.host_addr (haddr_s1),
		.host_data (hdata_s1),
		.ra_val    (ra_val),
		.rb_val    (rb_val),
		.pc        (pc_q),
		.flags     (flags_q),
		.halted    (halted_q),
		.eo        (eo),
		.dm_we     (dm_we),
		.dm_re     (dm_re),
		.dm_addr   (dm_addr),
		.dm_wdata  (dm_wdata)
	);

	r16ie_dmem #(.DATA_DEPTH(DATA_DEPTH)) u_dmem (
		.clk       (clk),
		.arst_n    (arst_n),
		.busy      (dm_busy),
		.acc_we    (valid_s1 && dm_we),
		.acc_re    (valid_s1 && dm_re),
		.acc_addr  (dm_addr),
		.acc_wdata (dm_wdata),
		.rd_data   (dm_rdata)
	);

	// Pc, flags and halt settle at the end of the execute stage, well before
	// the next item reaches it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			flags_q  <= '0;
			halted_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				pc_q     <= eo.res.next_pc;
				flags_q  <= eo.res.flags;
				halted_q <= eo.res.halted;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2   <= eo.res;
			load_s2  <= eo.load;
			hread_s2 <= eo.host_read;
		end
	end

	// Memory read data lands here for loads and host reads.
	always_comb begin
		res_fin = res_s2;
		if (load_s2) begin
			res_fin.reg_write_value = dm_rdata;
		end
		if (hread_s2) begin
			res_fin.read_data = dm_rdata;
		end
	end

	assign rf_we = valid_s2 && res_s2.reg_write_en;

	// Result buffer: every beat leaving the write-back stage is pushed.
	assign out_pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (valid_s2) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (valid_s2 && !out_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!valid_s2 && out_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			buf_q[wr_ptr_q] <= res_fin;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = OUT_TDATA_W'(buf_q[rd_ptr_q]);

	// Two items are never accepted back to back.
	a_item_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !in_accept)
		else $error("two items accepted in consecutive cycles");

	// The result buffer never receives a beat while full.
	a_buf_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((cnt_q != 2'd2) || out_pop))
		else $error("result buffer overflow");

	// Once halted, the core stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	// No item enters while the data memory sweep is running.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		dm_busy |-> !valid_s1 && !valid_s2)
		else $error("item in flight during memory clear");

endmodule

@@ tb/risc16_instruction_execute_tb.sv @@
// ----------------------------------------------------------------------------
// risc16_instruction_execute_tb
// Self-checking stream testbench for the 16-bit execute core.
// ----------------------------------------------------------------------------
// A driver process feeds input beats from a queue of pending items. As each
// beat is accepted, an in-bench model of the core updates its own pc, flags,
// halt state, register file and data memory, and queues the predicted result
// beat. A monitor process compares every output beat, field by field, with the
// oldest prediction. Both stream sides idle in random bursts. Once in the run
// the output side is held off long enough that the core must stall its input.
// ----------------------------------------------------------------------------
module risc16_instruction_execute_tb;
	import r16ie_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_DEPTH   = DATA_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_TAIL  = 60;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 200;

	// Codes that the package leaves unnamed but the stimulus needs.
	localparam logic [FUNC_W-1:0] FUNC_NOP  = 2'd3;
	localparam logic [2:0]        OP2_NONE  = 3'd3;
	localparam logic [2:0]        COND_NONE = 3'd6;
	localparam logic [3:0]        OP3_IN    = 4'd12;
	localparam logic [3:0]        OP3_OUT   = 4'd13;
	localparam logic [3:0]        OP3_GAP7  = 4'd7;
	localparam logic [3:0]        OP3_GAP14 = 4'd14;

	// One input item as the host sees it.
	typedef struct packed {
		logic [FUNC_W-1:0]     func;
		logic [WORD_BITS-1:0]  instr;
		logic [MEM_ADDR_W-1:0] addr;
		logic [WORD_BITS-1:0]  data;
	} core_item_t;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   s_axis_tvalid  = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
	logic [FUNC_W-1:0]      s_axis_tuser   = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Architectural state of the model core.
	logic [WORD_BITS-1:0] pc_state;
	logic [FLAGS_W-1:0]   flag_state;
	logic                 halt_state;
	logic [WORD_BITS-1:0] reg_file [REG_COUNT];
	logic [WORD_BITS-1:0] mem_image [MEM_DEPTH];

	core_item_t program_q[$];
	result_t    core_results_q[$];
	core_item_t beat_item;

	int          err_cnt    = 0;
	int          beats_in   = 0;
	int          beats_out  = 0;
	int          item_total = 0;
	int          send_gap   = 0;
	int          recv_stall = 0;
	int          hold_left  = 0;
	bit          hold_done  = 1'b0;
	int unsigned cycle_cnt  = 0;
	logic        quiet;

	// The last stretch of the run has no idling on either side.
	assign quiet = beats_in >= item_total - QUIET_TAIL;

	risc16_instruction_execute u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// ------------------------------------------------------------------------
	// Instruction encoders.
	// ------------------------------------------------------------------------
	function automatic logic [15:0] mem_word(input logic [1:0] major, input logic [2:0] ra,
			input logic [2:0] rb, input logic [7:0] disp);
		return {major, ra, rb, disp};
	endfunction

	function automatic logic [15:0] br_word(input logic [2:0] op2, input logic [2:0] sel,
			input logic [7:0] disp);
		return {OP1_BR, op2, sel, disp};
	endfunction

	function automatic logic [15:0] alu_word(input logic [3:0] op3, input logic [2:0] rs,
			input logic [2:0] rd, input logic [3:0] sh);
		return {OP1_ALU, rs, rd, op3, sh};
	endfunction

	task automatic push_item(input logic [FUNC_W-1:0] func, input logic [15:0] instr,
			input logic [MEM_ADDR_W-1:0] addr, input logic [15:0] data);
		core_item_t it;
		it.func  = func;
		it.instr = instr;
		it.addr  = addr;
		it.data  = data;
		program_q.insert(program_q.size(), it);
	endtask

	// Host addresses fall half the time into the window that loads and stores
	// reach from small register values, so loads see host-written data.
	function automatic logic [MEM_ADDR_W-1:0] host_addr();
		logic [2:0] top;
		if ($urandom_range(0, 1) == 0)
			return MEM_ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
		top = ($urandom_range(0, 1) == 0) ? 3'b000 : 3'b111;
		return {top, 8'($urandom)};
	endfunction

	// ------------------------------------------------------------------------
	// Model core: runs one item against the bench's copy of the state and
	// returns the result beat that the core should produce for it.
	// ------------------------------------------------------------------------
	function automatic result_t core_execute(input core_item_t it);
		result_t              r;
		logic [1:0]           major;
		logic [2:0]           fa;
		logic [2:0]           fb;
		logic [3:0]           op3;
		logic [3:0]           sh;
		logic [WORD_BITS-1:0] disp;
		logic [WORD_BITS-1:0] npc;
		logic [WORD_BITS-1:0] x;
		logic [WORD_BITS-1:0] y;
		logic [WORD_BITS-1:0] v;
		logic [FLAGS_W-1:0]   nf;
		logic                 taken;
		logic                 z;
		logic                 lt;
		logic                 sets_zs;
		logic                 writes;
		int                   ea;

		r = '0;
		if (it.func == FUNC_MEM_WRITE) begin
			mem_image[it.addr] = it.data;
		end else if (it.func == FUNC_MEM_READ) begin
			r.read_data = mem_image[it.addr];
		end else if (it.func == FUNC_EXEC && !halt_state) begin
			major = it.instr[15:14];
			fa    = it.instr[13:11];
			fb    = it.instr[10:8];
			disp  = {{8{it.instr[7]}}, it.instr[7:0]};
			npc   = pc_state + 16'd1;
			case (major)
				OP1_LD, OP1_ST: begin
					// Effective address is a signed sum, wrapped into the memory.
					ea = $signed(reg_file[fb]) + $signed(disp);
					ea = ea % MEM_DEPTH;
					if (ea < 0)
						ea += MEM_DEPTH;
					if (major == OP1_LD) begin
						reg_file[fa]      = mem_image[MEM_ADDR_W'(ea)];
						r.reg_write_en    = 1'b1;
						r.reg_write_index = fa;
						r.reg_write_value = reg_file[fa];
					end else begin
						mem_image[MEM_ADDR_W'(ea)] = reg_file[fa];
						r.mem_write_en    = 1'b1;
						r.mem_write_addr  = MEM_ADDR_W'(ea);
						r.mem_write_value = reg_file[fa];
					end
				end
				OP1_BR: begin
					if (fa == IS_IF) begin
						z  = flag_state[FLAG_Z];
						lt = flag_state[FLAG_S] ^ flag_state[FLAG_V];
						case (fb)
							COND_EQ: taken = z;
							COND_LT: taken = lt;
							COND_LE: taken = z | lt;
							COND_NE: taken = !z;
							default: taken = 1'b0;
						endcase
						if (taken)
							npc = npc + disp;
					end else if (fa == OP2_LI) begin
						reg_file[fb]      = disp;
						r.reg_write_en    = 1'b1;
						r.reg_write_index = fb;
						r.reg_write_value = disp;
					end else if (fa == OP2_B) begin
						npc = npc + disp;
					end
				end
				default: begin
					// Every ALU-group instruction starts from cleared flags.
					op3     = it.instr[7:4];
					sh      = it.instr[3:0];
					x       = reg_file[fb];
					y       = reg_file[fa];
					v       = '0;
					nf      = '0;
					sets_zs = 1'b1;
					writes  = 1'b1;
					case (op3)
						OP3_ADD: begin
							v = x + y;
							if (x[15] == y[15] && v[15] != x[15]) begin
								nf[FLAG_V] = 1'b1;
								nf[FLAG_C] = 1'b1;
							end
						end
						OP3_SUB, OP3_CMP: begin
							v = x - y;
							if (x[15] != y[15] && v[15] != x[15]) begin
								nf[FLAG_V] = 1'b1;
								nf[FLAG_C] = 1'b1;
							end
							writes = (op3 != OP3_CMP);
						end
						OP3_AND: v = x & y;
						OP3_OR:  v = x | y;
						OP3_XOR: v = x ^ y;
						OP3_MOV: v = y;
						OP3_SLL: v = x << sh;
						OP3_ROL: v = (sh == 0) ? x : ((x << sh) | (x >> (16 - sh)));
						OP3_SRL: v = x >> sh;
						OP3_SRA: v = $signed(x) >>> sh;
						HLT: begin
							halt_state = 1'b1;
							sets_zs    = 1'b0;
							writes     = 1'b0;
						end
						default: begin
							sets_zs = 1'b0;
							writes  = 1'b0;
						end
					endcase
					if (sets_zs) begin
						nf[FLAG_Z] = (v == '0);
						nf[FLAG_S] = v[15];
						if (writes) begin
							reg_file[fb]      = v;
							r.reg_write_en    = 1'b1;
							r.reg_write_index = fb;
							r.reg_write_value = v;
						end
					end
					flag_state = nf;
				end
			endcase
			pc_state = npc;
		end
		r.next_pc = pc_state;
		r.halted  = halt_state;
		r.flags   = flag_state;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		err_cnt++;
		if (err_cnt <= PRINT_LIMIT)
			$display("%0t ns result beat %0d: %s is %h, predicted %h",
				$time, beats_out, what, got, want);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (core_results_q.size() == 0) begin
			report_mismatch("beat with no pending prediction, next_pc", got.next_pc, '0);
			return;
		end
		want = core_results_q.pop_front();
		if (got.next_pc !== want.next_pc)
			report_mismatch("next_pc", got.next_pc, want.next_pc);
		if (got.halted !== want.halted)
			report_mismatch("halted", WORD_BITS'(got.halted), WORD_BITS'(want.halted));
		if (got.flags !== want.flags)
			report_mismatch("flags", WORD_BITS'(got.flags), WORD_BITS'(want.flags));
		if (got.reg_write_en !== want.reg_write_en)
			report_mismatch("reg_write_en", WORD_BITS'(got.reg_write_en),
				WORD_BITS'(want.reg_write_en));
		if (got.reg_write_index !== want.reg_write_index)
			report_mismatch("reg_write_index", WORD_BITS'(got.reg_write_index),
				WORD_BITS'(want.reg_write_index));
		if (got.reg_write_value !== want.reg_write_value)
			report_mismatch("reg_write_value", got.reg_write_value, want.reg_write_value);
		if (got.mem_write_en !== want.mem_write_en)
			report_mismatch("mem_write_en", WORD_BITS'(got.mem_write_en),
				WORD_BITS'(want.mem_write_en));
		if (got.mem_write_addr !== want.mem_write_addr)
			report_mismatch("mem_write_addr", WORD_BITS'(got.mem_write_addr),
				WORD_BITS'(want.mem_write_addr));
		if (got.mem_write_value !== want.mem_write_value)
			report_mismatch("mem_write_value", got.mem_write_value, want.mem_write_value);
		if (got.read_data !== want.read_data)
			report_mismatch("read_data", got.read_data, want.read_data);
		beats_out++;
	endtask

	// ------------------------------------------------------------------------
	// Driver. When the current beat is taken (or none is offered) the next
	// item is popped, unless a random idle burst is running. The prediction
	// for a beat is made on the edge that accepts it, so it follows the exact
	// order in which the core sees the items.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				core_results_q.insert(core_results_q.size(), core_execute(beat_item));
				beats_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (program_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (!quiet && hold_left == 0 && (beats_in / 50) % 3 != 2 &&
						$urandom_range(0, 5) == 0) begin
					// Idle burst of random length; every third block of
					// items runs with no gaps at all.
					send_gap      <= $urandom_range(0, 16);
					s_axis_tvalid <= 1'b0;
				end else begin
					beat_item      = program_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {5'b0, beat_item.data, beat_item.addr, beat_item.instr};
					s_axis_tuser  <= beat_item.func;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long hold-off on the output side, once, partway through the random part.
	// The sender keeps offering beats meanwhile, so the output buffer fills and
	// the core has to drop tready on its input.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_in >= 220) begin
			hold_left <= 160;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Checks each accepted result beat and stalls tready in random
	// bursts, with stretches of steady acceptance in between.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata[RESULT_W-1:0]);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall    <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (!quiet && (cycle_cnt / 300) % 3 != 1 && $urandom_range(0, 9) == 0) begin
				recv_stall    <= $urandom_range(0, 16);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// The core sweeps its memory after reset, so the limit leaves room for
	// that on top of the slowest item stream.
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------------
	initial begin
		logic [15:0] word;
		logic [2:0]  sel;
		int          pick;
		int          cls;

		pc_state   = '0;
		flag_state = '0;
		halt_state = 1'b0;
		for (int i = 0; i < REG_COUNT; i++)
			reg_file[i] = '0;
		for (int i = 0; i < MEM_DEPTH; i++)
			mem_image[i] = '0;

		// Directed part: host access at the address extremes, then registers
		// loaded with the most negative and most positive words so that add
		// and subtract overflow, all branch conditions, shifts by 0 and 15,
		// the opcodes that only clear flags, and the unused branch-group codes.
		push_item(FUNC_MEM_WRITE, 16'h0000, 11'd2047, 16'h8000);
		push_item(FUNC_MEM_WRITE, 16'hFFFF, 11'd0, 16'h7FFF);
		push_item(FUNC_MEM_READ, 16'hFFFF, 11'd2047, 16'hFFFF);
		push_item(FUNC_NOP, 16'hFFFF, 11'd2047, 16'hFFFF);
		push_item(FUNC_EXEC, br_word(OP2_LI, 3'd1, 8'h7F), '0, '0);
		push_item(FUNC_EXEC, br_word(OP2_LI, 3'd2, 8'h80), '0, '0);
		push_item(FUNC_EXEC, mem_word(OP1_LD, 3'd3, 3'd0, 8'hFF), '0, '0);
		push_item(FUNC_EXEC, mem_word(OP1_LD, 3'd4, 3'd0, 8'h00), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_ADD, 3'd4, 3'd4, 4'd0), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_SUB, 3'd1, 3'd3, 4'd0), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_CMP, 3'd4, 3'd4, 4'd0), '0, '0);
		push_item(FUNC_EXEC, br_word(IS_IF, COND_EQ, 8'd5), '0, '0);
		push_item(FUNC_EXEC, br_word(IS_IF, COND_NE, 8'hFD), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_SRA, 3'd0, 3'd3, 4'd15), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_SLL, 3'd0, 3'd1, 4'd15), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_ROL, 3'd0, 3'd2, 4'd0), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_SRL, 3'd0, 3'd2, 4'd15), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_XOR, 3'd3, 3'd5, 4'd0), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_MOV, 3'd3, 3'd7, 4'd0), '0, '0);
		push_item(FUNC_EXEC, br_word(IS_IF, COND_LT, 8'h10), '0, '0);
		push_item(FUNC_EXEC, br_word(IS_IF, COND_LE, 8'h80), '0, '0);
		push_item(FUNC_EXEC, mem_word(OP1_ST, 3'd4, 3'd2, 8'h80), '0, '0);
		push_item(FUNC_EXEC, br_word(OP2_B, 3'd0, 8'h80), '0, '0);
		push_item(FUNC_EXEC, br_word(IS_IF, COND_NONE, 8'h7F), '0, '0);
		push_item(FUNC_EXEC, br_word(OP2_NONE, 3'd5, 8'h33), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_IN, 3'd1, 3'd2, 4'd3), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_OUT, 3'd1, 3'd2, 4'd3), '0, '0);

		// Random part. Execute items dominate; host writes seed the memory
		// window that loads reach, and load-immediates seed the registers so
		// the ALU and branches work on live values. A halt would end all
		// execution, so it is kept out of here.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			word = 16'($urandom);
			if (pick < 12) begin
				push_item(FUNC_MEM_WRITE, word, host_addr(), 16'($urandom));
			end else if (pick < 24) begin
				push_item(FUNC_MEM_READ, word, host_addr(), 16'($urandom));
			end else if (pick < 26) begin
				push_item(FUNC_NOP, word, host_addr(), 16'($urandom));
			end else begin
				cls = $urandom_range(0, 9);
				case (cls)
					0, 1: word = {OP1_LD, word[13:0]};
					2:    word = {OP1_ST, word[13:0]};
					3, 4: word = {OP1_BR, OP2_LI, word[10:0]};
					5: begin
						sel  = ($urandom_range(0, 4) == 0) ? word[10:8]
							: 3'($urandom_range(0, 3));
						word = br_word(IS_IF, sel, word[7:0]);
					end
					6:    word = {OP1_BR, word[13:0]};
					default: word = alu_word(4'($urandom_range(0, 14)), word[13:11],
						word[10:8], word[3:0]);
				endcase
				push_item(FUNC_EXEC, word, host_addr(), 16'($urandom));
			end
		end

		// Halt, then show that execute items change nothing while host
		// accesses still work.
		push_item(FUNC_EXEC, alu_word(HLT, 3'd0, 3'd0, 4'd0), '0, '0);
		push_item(FUNC_EXEC, mem_word(OP1_ST, 3'd1, 3'd0, 8'h00), '0, '0);
		push_item(FUNC_EXEC, br_word(OP2_LI, 3'd6, 8'h55), '0, '0);
		push_item(FUNC_EXEC, alu_word(OP3_ADD, 3'd1, 3'd1, 4'd0), '0, '0);
		push_item(FUNC_MEM_WRITE, '0, 11'd5, 16'hA5A5);
		push_item(FUNC_MEM_READ, '0, 11'd5, '0);
		push_item(FUNC_NOP, '0, '0, '0);
		item_total = program_q.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_in < item_total)
			@(posedge clk);
		while (core_results_q.size() != 0)
			@(posedge clk);
		// Run on after that, to catch any stray beat after the last one.
		repeat (16) @(posedge clk);

		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
